### rtl/pdet_pkg.sv
// shared types, constants and helpers of the 2-d peak detector
package pdet_pkg;

    // defaults for the top level parameters
    localparam int PD_MAX_COLS     = 1024;
    localparam int PD_SAMPLE_WIDTH = 32;

    // row limit only bounds the clamp of the row register
    localparam int unsigned MAX_ROWS = 1024;

    // widths fixed by the register and result fields
    localparam int DIM_WIDTH       = 11;
    localparam int COUNT_WIDTH     = 21;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [DIM_WIDTH-1:0]   DIM_RESET = 11'd1024;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_COLS = 2'd1;

    typedef enum logic [0:0] {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // line store controls for one accepted item
    typedef struct packed {
        logic advance;
        logic wr_en;
    } win_ctrl_t;

    // one result item
    typedef struct packed {
        logic                   is_peak;
        logic [DIM_WIDTH-1:0]   peak_row;
        logic [DIM_WIDTH-1:0]   peak_col;
        logic [COUNT_WIDTH-1:0] peak_count;
        logic                   frame_end;
    } result_t;

    // zero reads as one, anything above the limit reads as the limit
    function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] v,
                                                       input int unsigned maxv);
        logic [DIM_WIDTH-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = DIM_WIDTH'(1);
        end
        else if (32'(v) > maxv)
        begin
            res = DIM_WIDTH'(maxv);
        end
        return res;
    endfunction

endpackage

### rtl/pdet_window.sv
// line stores and the 3-column read-ahead window around the current column
module pdet_window
    import pdet_pkg::*;
#(
    parameter int MAX_COLS     = PD_MAX_COLS,
    parameter int SAMPLE_WIDTH = PD_SAMPLE_WIDTH,
    parameter int COL_AW       = $clog2(MAX_COLS)
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  win_ctrl_t                      ctrl,
    input  logic [COL_AW-1:0]              wr_addr,
    input  logic [COL_AW-1:0]              up_addr,
    input  logic [COL_AW-1:0]              mid_addr,
    input  logic signed [SAMPLE_WIDTH-1:0] pixel,
    output logic signed [SAMPLE_WIDTH-1:0] cen,
    output logic signed [SAMPLE_WIDTH-1:0] up,
    output logic signed [SAMPLE_WIDTH-1:0] lft,
    output logic signed [SAMPLE_WIDTH-1:0] rgt
);

    logic signed [SAMPLE_WIDTH-1:0] upper_mem  [MAX_COLS];
    logic signed [SAMPLE_WIDTH-1:0] middle_mem [MAX_COLS];

    logic signed [SAMPLE_WIDTH-1:0] cen_reg;
    logic signed [SAMPLE_WIDTH-1:0] cen_next;
    logic signed [SAMPLE_WIDTH-1:0] lft_reg;
    logic signed [SAMPLE_WIDTH-1:0] up_raw_reg;
    logic signed [SAMPLE_WIDTH-1:0] rgt_raw_reg;
    logic signed [SAMPLE_WIDTH-1:0] up_fd_reg;
    logic signed [SAMPLE_WIDTH-1:0] rgt_fd_reg;
    logic                           up_fwd_reg;
    logic                           up_fwd_next;
    logic                           rgt_fwd_reg;
    logic                           rgt_fwd_next;

    // read address meets this cycle's write only on very narrow frames
    assign up_fwd_next  = ctrl.wr_en && (up_addr == wr_addr);
    assign rgt_fwd_next = ctrl.wr_en && (mid_addr == wr_addr);

    assign up  = up_fwd_reg  ? up_fd_reg  : up_raw_reg;
    assign rgt = rgt_fwd_reg ? rgt_fd_reg : rgt_raw_reg;
    assign cen = cen_reg;
    assign lft = lft_reg;

    // next centre is the old right neighbour, or the sample just written
    assign cen_next = up_fwd_next ? pixel : rgt;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            upper_mem[wr_addr]  <= cen_reg;
            middle_mem[wr_addr] <= pixel;
        end
        if (ctrl.advance)
        begin
            up_raw_reg  <= upper_mem[up_addr];
            rgt_raw_reg <= middle_mem[mid_addr];
            up_fd_reg   <= cen_reg;
            rgt_fd_reg  <= pixel;
            cen_reg     <= cen_next;
            lft_reg     <= cen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_fwd_reg  <= 1'b0;
            rgt_fwd_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            up_fwd_reg  <= up_fwd_next;
            rgt_fwd_reg <= rgt_fwd_next;
        end
    end

    // a single-column frame forwards into both read-ahead slots
    a_fwd_pair: assert property (@(posedge clk) disable iff (!rst_n)
        up_fwd_reg |-> rgt_fwd_reg)
        else $error("up forward without right forward");

    a_wr_adv: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |=> (up_fwd_reg == $past(up_fwd_next)))
        else $error("forward flag not taken with write");

endmodule

### rtl/pdet_ctrl.sv
// frame position, configuration, peak decision and running count
module pdet_ctrl
    import pdet_pkg::*;
#(
    parameter int MAX_COLS     = PD_MAX_COLS,
    parameter int SAMPLE_WIDTH = PD_SAMPLE_WIDTH,
    parameter int COL_AW       = $clog2(MAX_COLS)
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [DIM_WIDTH-1:0]           cfg_data,
    input  logic                           accept,
    input  cmd_t                           command,
    input  logic signed [SAMPLE_WIDTH-1:0] pixel,
    input  logic signed [SAMPLE_WIDTH-1:0] cen,
    input  logic signed [SAMPLE_WIDTH-1:0] up,
    input  logic signed [SAMPLE_WIDTH-1:0] lft,
    input  logic signed [SAMPLE_WIDTH-1:0] rgt,
    output win_ctrl_t                      win_ctrl,
    output logic [COL_AW-1:0]              wr_addr,
    output logic [COL_AW-1:0]              up_addr,
    output logic [COL_AW-1:0]              mid_addr,
    output result_t                        result
);

    localparam int CW = ((COL_AW > DIM_WIDTH) ? COL_AW : DIM_WIDTH) + 1;

    logic [DIM_WIDTH-1:0]   rows_reg;
    logic [DIM_WIDTH-1:0]   rows_next;
    logic [DIM_WIDTH-1:0]   cols_reg;
    logic [DIM_WIDTH-1:0]   cols_next;
    logic [DIM_WIDTH-1:0]   in_row_reg;
    logic [DIM_WIDTH-1:0]   in_row_next;
    logic [COL_AW-1:0]      in_col_reg;
    logic [COL_AW-1:0]      in_col_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    logic [CW-1:0] c_w;
    logic [CW-1:0] cols_w;
    logic [CW-1:0] a1_w;
    logic [CW-1:0] a2_w;
    logic          last_col;
    logic          is_pixel;
    logic          is_flush;
    logic          up_ok_pix;
    logic          up_ok_flush;
    logic          lft_ok;
    logic          rgt_ok;
    logic          down_ok;
    logic          peak;
    logic          frame_done;

    // column arithmetic and read-ahead addresses, wrapping at the row end
    always_comb
    begin
        c_w      = CW'(in_col_reg);
        cols_w   = CW'(cols_reg);
        last_col = (c_w + CW'(1)) == cols_w;
        a1_w     = last_col ? '0 : c_w + CW'(1);
        a2_w     = ((a1_w + CW'(1)) == cols_w) ? '0 : a1_w + CW'(1);
    end

    assign wr_addr  = in_col_reg;
    assign up_addr  = a1_w[COL_AW-1:0];
    assign mid_addr = a2_w[COL_AW-1:0];

    // neighbour tests, each passes when that neighbour is absent
    always_comb
    begin
        down_ok     = cen >= pixel;
        up_ok_pix   = !((in_row_reg > DIM_WIDTH'(1)) && (cen < up));
        up_ok_flush = !((rows_reg > DIM_WIDTH'(1)) && (cen < up));
        lft_ok      = !((in_col_reg != '0) && (cen < lft));
        rgt_ok      = !(!last_col && (cen < rgt));
    end

    assign is_pixel = (command == CMD_PIXEL) && (in_row_reg < rows_reg);
    assign is_flush = (command == CMD_FLUSH) && (in_row_reg == rows_reg);

    always_comb
    begin
        rows_next        = rows_reg;
        cols_next        = cols_reg;
        in_row_next      = in_row_reg;
        in_col_next      = in_col_reg;
        count_next       = count_reg;
        win_ctrl.advance = 1'b0;
        win_ctrl.wr_en   = 1'b0;
        peak             = 1'b0;
        frame_done       = 1'b0;
        result.peak_row  = '0;
        result.peak_col  = '0;

        if (is_pixel)
        begin
            win_ctrl.advance = accept;
            win_ctrl.wr_en   = accept;
            if (in_row_reg != '0)
            begin
                peak            = down_ok && up_ok_pix && lft_ok && rgt_ok;
                result.peak_row = in_row_reg;
                result.peak_col = DIM_WIDTH'(c_w + CW'(1));
            end
            if (last_col)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + DIM_WIDTH'(1);
            end
            else
            begin
                in_col_next = a1_w[COL_AW-1:0];
            end
        end
        else if (is_flush)
        begin
            win_ctrl.advance = accept;
            peak             = up_ok_flush && lft_ok && rgt_ok;
            frame_done       = last_col;
            result.peak_row  = rows_reg;
            result.peak_col  = DIM_WIDTH'(c_w + CW'(1));
            in_col_next      = a1_w[COL_AW-1:0];
        end

        if (peak && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end

        result.is_peak    = peak;
        result.peak_count = count_next;
        result.frame_end  = frame_done;

        // last flush item starts a new frame
        if (frame_done)
        begin
            in_row_next = '0;
            in_col_next = '0;
            count_next  = '0;
        end

        if (!accept)
        begin
            in_row_next = in_row_reg;
            in_col_next = in_col_reg;
            count_next  = count_reg;
        end

        // any known register write restarts the frame
        if (cfg_write && ((cfg_index == REG_FRAME_ROWS) || (cfg_index == REG_FRAME_COLS)))
        begin
            if (cfg_index == REG_FRAME_ROWS)
            begin
                rows_next = clamp_dim(cfg_data, MAX_ROWS);
            end
            else
            begin
                cols_next = clamp_dim(cfg_data, MAX_COLS);
            end
            in_row_next = '0;
            in_col_next = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= clamp_dim(DIM_RESET, MAX_ROWS);
            cols_reg   <= clamp_dim(DIM_RESET, MAX_COLS);
            in_row_reg <= '0;
            in_col_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            count_reg  <= count_next;
        end
    end

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(in_col_reg) < CW'(cols_reg))
        else $error("input column beyond frame width");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= rows_reg)
        else $error("input row beyond frame height");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_done) |=> ((in_row_reg == '0) && (in_col_reg == '0)
                                    && (count_reg == '0)))
        else $error("frame not restarted after last flush item");

endmodule

### rtl/peak_detect_2d_stream_unit.sv
// top level of the streaming four-neighbour 2-d peak detector
//
// Samples of a frame_rows x frame_cols matrix enter in row-major order, one
// item per clock cycle with no bubbles unless stalled: each accepted item
// gives exactly one result item, registered, in the cycle after acceptance.
// The rate is set by the two line stores (upper and middle), each MAX_COLS
// deep, written and read at most once per item; the window around the current
// column is read one column ahead, so the neighbour compare of the next item
// never waits on a memory read. A position is decided when the sample below
// it arrives; after the frame, frame_cols flush items (command 1) decide the
// last row, and the final one raises frame_end and starts a new frame. Extra
// pixels and early flush items give an empty result that only carries the
// count. Writing frame_rows or frame_cols restarts the frame; the line stores
// have no clearing pass and need no warm-up after reset.
module peak_detect_2d_stream_unit
    import pdet_pkg::*;
#(
    parameter int MAX_COLS     = PD_MAX_COLS,
    parameter int SAMPLE_WIDTH = PD_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [DIM_WIDTH-1:0]           cfg_data,

    // sample channel
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  logic                           command,
    input  logic signed [SAMPLE_WIDTH-1:0] pixel_value,

    // result channel
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           is_peak,
    output logic [DIM_WIDTH-1:0]           peak_row,
    output logic [DIM_WIDTH-1:0]           peak_col,
    output logic [COUNT_WIDTH-1:0]         peak_count,
    output logic                           frame_end
);

    localparam int COL_AW = $clog2(MAX_COLS);

    logic                           accept;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    result_t                        res_reg;
    result_t                        res_next;
    win_ctrl_t                      win_ctrl;
    logic [COL_AW-1:0]              wr_addr;
    logic [COL_AW-1:0]              up_addr;
    logic [COL_AW-1:0]              mid_addr;
    logic signed [SAMPLE_WIDTH-1:0] cen;
    logic signed [SAMPLE_WIDTH-1:0] up;
    logic signed [SAMPLE_WIDTH-1:0] lft;
    logic signed [SAMPLE_WIDTH-1:0] rgt;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // the result register takes a new item whenever it is empty or leaving
    assign pix_stall = res_valid_reg && res_stall;
    assign accept    = pix_valid && !pix_stall;

    pdet_ctrl #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COL_AW       (COL_AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .command   (cmd_t'(command)),
        .pixel     (pixel_value),
        .cen       (cen),
        .up        (up),
        .lft       (lft),
        .rgt       (rgt),
        .win_ctrl  (win_ctrl),
        .wr_addr   (wr_addr),
        .up_addr   (up_addr),
        .mid_addr  (mid_addr),
        .result    (res_next)
    );

    pdet_window #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COL_AW       (COL_AW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (win_ctrl),
        .wr_addr  (wr_addr),
        .up_addr  (up_addr),
        .mid_addr (mid_addr),
        .pixel    (pixel_value),
        .cen      (cen),
        .up       (up),
        .lft      (lft),
        .rgt      (rgt)
    );

    // result register valid: set by an accepted item, cleared when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, loaded only with an accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign is_peak    = res_reg.is_peak;
    assign peak_row   = res_reg.peak_row;
    assign peak_col   = res_reg.peak_col;
    assign peak_count = res_reg.peak_count;
    assign frame_end  = res_reg.frame_end;

    // a peak or a frame end always names a decided position
    a_peak_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (is_peak || frame_end)) |-> ((peak_row != '0) && (peak_col != '0)))
        else $error("peak or frame end without a position");

    // an accepted item always shows up as a result in the next cycle
    a_accept_res: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("accepted item produced no result");

endmodule

### tb/sv/peak_detect_2d_stream_unit_test.sv
// self-checking testbench of the streaming four-neighbour 2-d peak detector
module peak_detect_2d_stream_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pdet_pkg::*;

    localparam int SW = PD_SAMPLE_WIDTH;

    // idling odds in percent per cycle, and the fixed hold-off lengths
    localparam int HEAVY_IDLE_PCT = 55;
    localparam int LIGHT_IDLE_PCT = 9;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 8;

    // generous bound on the whole run, well above the slowest legal one
    localparam int unsigned TIMEOUT_NS = 2_000_000;

    // an index with no register behind it: a write there must change nothing
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [SW-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    // no position decided, count still zero
    localparam result_t NO_DECISION = '0;
    // a 1x1 frame: the lone sample is a peak, first of the frame, and ends it
    localparam result_t LONE_PEAK   = '{1'b1, 11'd1, 11'd1, 21'd1, 1'b1};

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum {ROW_ITEM, ROW_WRITE} row_kind_t;

    // one line of the directed stimulus table
    typedef struct {
        row_kind_t                  kind;
        cmd_t                       cmd;
        sample_t                    value;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [DIM_WIDTH-1:0]       data;
        bit                         typed;
        result_t                    want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [DIM_WIDTH-1:0]       cfg_data;
    logic                       pix_valid;
    logic                       pix_stall;
    logic                       command;
    sample_t                    pixel_value;
    logic                       res_valid;
    logic                       res_stall;
    logic                       is_peak;
    logic [DIM_WIDTH-1:0]       peak_row;
    logic [DIM_WIDTH-1:0]       peak_col;
    logic [COUNT_WIDTH-1:0]     peak_count;
    logic                       frame_end;

    peak_detect_2d_stream_unit dut (.*);

    // own copy of the detector state: two line stores, input position, count
    sample_t                upper_copy [PD_MAX_COLS];
    sample_t                middle_copy [PD_MAX_COLS];
    int unsigned            next_row;
    int unsigned            next_col;
    logic [COUNT_WIDTH-1:0] peaks_so_far;
    logic [DIM_WIDTH-1:0]   rows_reg;
    logic [DIM_WIDTH-1:0]   cols_reg;

    // results predicted for accepted items, oldest first
    result_t pending_results [$];
    result_t due_result;

    stim_row_t directed_rows [$];

    idle_mode_t idle_mode = IDLE_NONE;
    int         fails     = 0;

    // long receiver hold-off: asked for by the sender, counted by the receiver
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_pct;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // zero is taken as one, anything past the limit as the limit
    function automatic int unsigned dim_used(input logic [DIM_WIDTH-1:0] v,
                                             input int unsigned lim);
        if (v == '0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic void rewind_frame();
        next_row     = 0;
        next_col     = 0;
        peaks_so_far = '0;
    endfunction

    // result of one accepted item; advances the copied state
    function automatic result_t peak_decision(input cmd_t op, input sample_t sample);
        result_t     res;
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        sample_t     centre;
        logic        peak;
        logic        decided;
        logic        last;
        rows    = dim_used(rows_reg, MAX_ROWS);
        cols    = dim_used(cols_reg, PD_MAX_COLS);
        peak    = 1'b0;
        decided = 1'b0;
        last    = 1'b0;
        r       = 0;
        c       = 0;
        if (next_row > rows || next_col >= cols)
            rewind_frame();
        if (op == CMD_PIXEL && next_row < rows)
        begin
            c = next_col;
            // the sample below decides the position above it
            if (next_row > 0)
            begin
                centre  = middle_copy[c];
                r       = next_row - 1;
                peak    = (centre >= sample);
                if (r > 0 && centre < upper_copy[c])
                    peak = 1'b0;
                // left neighbour has already moved up into the upper store
                if (c > 0 && centre < upper_copy[c - 1])
                    peak = 1'b0;
                if (c + 1 < cols && centre < middle_copy[c + 1])
                    peak = 1'b0;
                decided = 1'b1;
            end
            upper_copy[c]  = middle_copy[c];
            middle_copy[c] = sample;
            next_col++;
            if (next_col >= cols)
            begin
                next_col = 0;
                next_row++;
            end
        end
        else if (op == CMD_FLUSH && next_row == rows)
        begin
            // last row has no neighbour below
            c      = next_col;
            r      = rows - 1;
            centre = middle_copy[c];
            peak   = 1'b1;
            if (r > 0 && centre < upper_copy[c])
                peak = 1'b0;
            if (c > 0 && centre < middle_copy[c - 1])
                peak = 1'b0;
            if (c + 1 < cols && centre < middle_copy[c + 1])
                peak = 1'b0;
            decided = 1'b1;
            next_col++;
            if (next_col >= cols)
                last = 1'b1;
        end
        if (decided && peak && peaks_so_far != COUNT_MAX)
            peaks_so_far++;
        res.is_peak    = peak;
        res.peak_row   = decided ? DIM_WIDTH'(r + 1) : '0;
        res.peak_col   = decided ? DIM_WIDTH'(c + 1) : '0;
        res.peak_count = peaks_so_far;
        res.frame_end  = last;
        if (last)
            rewind_frame();
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ---------------------------------------------------------------

    function automatic sample_t random_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return sample_t'($urandom);
            // a narrow range gives plenty of ties and plateaus
            default: return sample_t'($urandom_range(6)) - sample_t'(3);
        endcase
    endfunction

    function automatic stim_row_t item_row(input cmd_t op, input sample_t v,
                                           input bit typed = 1'b0,
                                           input result_t want = '0);
        stim_row_t row;
        row.kind  = ROW_ITEM;
        row.cmd   = op;
        row.value = v;
        row.index = '0;
        row.data  = '0;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                            input logic [DIM_WIDTH-1:0] val);
        stim_row_t row;
        row       = item_row(CMD_PIXEL, '0);
        row.kind  = ROW_WRITE;
        row.index = idx;
        row.data  = val;
        return row;
    endfunction

    // append one line to the directed table
    function automatic void add_row(input stim_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    // append one prediction behind the ones still waiting
    function automatic void queue_result(input result_t res);
        pending_results = {pending_results, res};
    endfunction

    // offer one item, possibly after an idle gap; predict it once taken
    task automatic push_item(input cmd_t op, input sample_t v, input bit typed,
                             input result_t want);
        int gap_pct;
        result_t predicted;
        gap_pct = (idle_mode == IDLE_SEND) ? HEAVY_IDLE_PCT :
                  (idle_mode == IDLE_BOTH) ? LIGHT_IDLE_PCT : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            pix_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        pix_valid   <= 1'b1;
        command     <= op;
        pixel_value <= v;
        do
            @(posedge clk);
        while (pix_stall !== 1'b0);
        predicted = peak_decision(op, v);
        queue_result(typed ? want : predicted);
        @(negedge clk);
    endtask

    // sender goes quiet until every predicted result has come out
    task automatic wait_drained();
        pix_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // register write, only with the block idle
    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [DIM_WIDTH-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        // either real register restarts the frame, other indexes do nothing
        if (idx == REG_FRAME_ROWS)
        begin
            rows_reg = val;
            rewind_frame();
        end
        else if (idx == REG_FRAME_COLS)
        begin
            cols_reg = val;
            rewind_frame();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one geometry: mostly whole frames with random samples, some noise
    task automatic run_phase(input idle_mode_t mode, input int frames,
                             input logic [DIM_WIDTH-1:0] rows_w,
                             input logic [DIM_WIDTH-1:0] cols_w,
                             input bit pressure);
        int unsigned rows;
        int unsigned cols;
        int unsigned cut;
        int unsigned k;
        int unsigned extra;
        int          f;
        if ($urandom_range(1))
        begin
            cfg_write(REG_FRAME_ROWS, rows_w);
            cfg_write(REG_FRAME_COLS, cols_w);
        end
        else
        begin
            cfg_write(REG_FRAME_COLS, cols_w);
            cfg_write(REG_FRAME_ROWS, rows_w);
        end
        idle_mode = mode;
        rows = dim_used(rows_w, MAX_ROWS);
        cols = dim_used(cols_w, PD_MAX_COLS);
        for (f = 0; f < frames; f++)
        begin
            // now and then a frame is broken off; the last one stays whole
            cut = rows * cols;
            if (f + 1 < frames && cut > 1 && $urandom_range(99) < 10)
                cut = $urandom_range(cut - 1, 1);
            for (k = 0; k < cut; k++)
            begin
                // receiver holds off while items keep coming
                if (pressure && f == 0 && k == 2)
                    hold_asks <= hold_asks + 1;
                // sender stops until the block has emptied
                if (pressure && f == 1 && k == 5)
                    wait_drained();
                // flush before the frame is in: ignored
                if ($urandom_range(99) < 3)
                    push_item(CMD_FLUSH, sample_t'($urandom), 1'b0, '0);
                push_item(CMD_PIXEL, random_sample(), 1'b0, '0);
            end
            // pixels past the last row: ignored
            extra = ($urandom_range(99) < 8) ? $urandom_range(3, 1) : 0;
            repeat (extra)
                push_item(CMD_PIXEL, random_sample(), 1'b0, '0);
            repeat (cols)
                push_item(CMD_FLUSH, sample_t'($urandom), 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // clock, receiver and result checking
    // ---------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // result stall, driven at the falling edge
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                stall_pct = (idle_mode == IDLE_RECV) ? HEAVY_IDLE_PCT :
                            (idle_mode == IDLE_BOTH) ? LIGHT_IDLE_PCT : 0;
                res_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // every taken result against the oldest prediction
    always @(posedge clk)
    begin
        if (res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no prediction pending");
                fails++;
            end
            else
            begin
                due_result = pending_results.pop_front();
                check_field("is_peak", due_result.is_peak, is_peak);
                check_field("peak_row", due_result.peak_row, peak_row);
                check_field("peak_col", due_result.peak_col, peak_col);
                check_field("peak_count", due_result.peak_count, peak_count);
                check_field("frame_end", due_result.frame_end, frame_end);
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int i;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        pix_valid   = 1'b0;
        command     = CMD_PIXEL;
        pixel_value = '0;
        foreach (upper_copy[j])
        begin
            upper_copy[j]  = '0;
            middle_copy[j] = '0;
        end
        rows_reg = DIM_RESET;
        cols_reg = DIM_RESET;
        rewind_frame();

        // after reset, 1024x1024: first row decides nothing, early flush ignored
        add_row(item_row(CMD_PIXEL, SAMPLE_MAX, 1'b1, NO_DECISION));
        add_row(item_row(CMD_PIXEL, SAMPLE_MIN, 1'b1, NO_DECISION));
        add_row(item_row(CMD_FLUSH, SAMPLE_MAX, 1'b1, NO_DECISION));
        // 2x3 frame: tied peak at a corner, extremes, a write to a spare index
        // mid-frame, one extra pixel, then the flush of the last row
        add_row(write_row(REG_FRAME_ROWS, 11'd2));
        add_row(write_row(REG_FRAME_COLS, 11'd3));
        add_row(item_row(CMD_PIXEL, 32'sd5));
        add_row(item_row(CMD_PIXEL, 32'sd5));
        add_row(item_row(CMD_PIXEL, SAMPLE_MIN));
        add_row(item_row(CMD_FLUSH, '0));
        add_row(write_row(REG_UNUSED, 11'h7FF));
        add_row(item_row(CMD_PIXEL, 32'sd5));
        add_row(item_row(CMD_PIXEL, SAMPLE_MAX));
        add_row(item_row(CMD_PIXEL, 32'sd7));
        add_row(item_row(CMD_PIXEL, SAMPLE_MIN));
        add_row(item_row(CMD_FLUSH, '0));
        add_row(item_row(CMD_FLUSH, '1));
        add_row(item_row(CMD_FLUSH, '0));
        // 1x1 frame
        add_row(write_row(REG_FRAME_ROWS, 11'd1));
        add_row(write_row(REG_FRAME_COLS, 11'd1));
        add_row(item_row(CMD_PIXEL, '0, 1'b1, NO_DECISION));
        add_row(item_row(CMD_FLUSH, '0, 1'b1, LONE_PEAK));
        // 2x2: a write part way through restarts the frame; flat frame after
        add_row(write_row(REG_FRAME_ROWS, 11'd2));
        add_row(write_row(REG_FRAME_COLS, 11'd2));
        add_row(item_row(CMD_PIXEL, 32'sd1));
        add_row(item_row(CMD_PIXEL, 32'sd2));
        add_row(item_row(CMD_PIXEL, 32'sd3));
        add_row(item_row(CMD_FLUSH, '0));
        add_row(write_row(REG_FRAME_COLS, 11'd2));
        repeat (4)
            add_row(item_row(CMD_PIXEL, -32'sd1));
        add_row(item_row(CMD_FLUSH, '0));
        add_row(item_row(CMD_FLUSH, '0));

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].kind == ROW_WRITE)
                cfg_write(directed_rows[n].index, directed_rows[n].data);
            else
                push_item(directed_rows[n].cmd, directed_rows[n].value,
                          directed_rows[n].typed, directed_rows[n].want);
        end

        // random part: flat out first, then the pressure run, then every
        // idling mode over random small geometries
        run_phase(IDLE_NONE, 4, 11'd3, 11'd4, 1'b0);
        run_phase(IDLE_NONE, 3, 11'd4, 11'd8, 1'b1);
        for (i = 0; i < 8; i++)
            run_phase(idle_mode_t'(i % 4), 2, DIM_WIDTH'($urandom_range(5, 1)),
                      DIM_WIDTH'($urandom_range(7, 1)), 1'b0);
        // register extremes: a zero in either register reads as one
        run_phase(IDLE_BOTH, 1, 11'd0, 11'd3, 1'b0);
        run_phase(IDLE_SEND, 1, 11'd2, 11'd0, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d predicted results never came out", pending_results.size());
            fails++;
        end
        if (fails == 0)
            $display("** peak_detect_2d_stream_unit: PASSED **");
        else
            $display("** peak_detect_2d_stream_unit: FAILED **");
        $finish;
    end

    // hung handshake guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("** peak_detect_2d_stream_unit: FAILED **");
        $finish;
    end

endmodule
